/* design/tfp_pkg.sv */
// ----------------------------------------------------------------------------
// tfp_pkg: shared types and constants of the timestamp field parser
// Byte item and result item types, character constants and status codes.
// ----------------------------------------------------------------------------
package tfp_pkg;

    localparam int IN_QUEUE_DEPTH  = 2;
    localparam int OUT_QUEUE_DEPTH = 2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    localparam logic [1:0] MODE_UTC  = 2'd0;
    localparam logic [1:0] MODE_ZONE = 2'd1;
    localparam logic [1:0] MODE_DATE = 2'd2;

    localparam logic [7:0] CH_SOH   = 8'h01;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    localparam logic [5:0] MAX_MONTH    = 6'd12;
    localparam logic [5:0] MAX_DAY      = 6'd31;
    localparam logic [5:0] MAX_HOUR     = 6'd23;
    localparam logic [5:0] MAX_MINUTE   = 6'd59;
    localparam logic [5:0] MAX_SECOND   = 6'd60;
    localparam logic [5:0] MAX_OFS_HOUR = 6'd12;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_soh;
        logic       is_digit;
        logic [3:0] dval;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [9:0]         millisecond;
        logic signed [10:0] zone_offset;
    } result_t;

endpackage

/* design/timestamp_field_parser_core.sv */
// ----------------------------------------------------------------------------
// timestamp_field_parser_core: byte-serial timestamp field parser
// Parses the ASCII bytes of one field value into date, time and zone fields.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on value_byte with push; a transfer happens when push is high
//   and full is low. The byte 0x01 ends a field and yields exactly one result;
//   other bytes yield none. Results leave through a queue: while empty is low
//   the oldest result is on the result ports, and pop takes it.
//   cfg_wr_en with cfg_wr_data selects the layout (0 timestamp with optional
//   milliseconds, 1 timestamp with zone, 2 dashed date); write it only while
//   no field is in flight.
//   Throughput is one byte per cycle while no end-of-field byte is held back
//   by a full result queue. A result appears once the end-of-field byte has
//   passed the byte queue and the parser has written it into the result queue.
//   When the receiver stalls, the result queue fills; the parser then holds
//   the end-of-field byte, the byte queue fills and full rises. Bytes that
//   produce no result keep flowing until an end-of-field byte is blocked.
//   Reset clears both queues, the parser state and the mode (to 0).
// ----------------------------------------------------------------------------
module timestamp_field_parser_core
    import tfp_pkg::*;
#(
    parameter int IN_DEPTH  = IN_QUEUE_DEPTH,
    parameter int OUT_DEPTH = OUT_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               push,
    input  logic [7:0]         value_byte,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output logic [1:0]         status,
    output logic [13:0]        year,
    output logic [3:0]         month,
    output logic [4:0]         day,
    output logic [4:0]         hour,
    output logic [5:0]         minute,
    output logic [5:0]         second,
    output logic [9:0]         millisecond,
    output logic signed [10:0] zone_offset
);

    logic       q_valid;
    logic       q_pop;
    byte_item_t q_item;
    logic       out_full;
    logic       res_push;
    result_t    res;
    result_t    res_head;

    tfp_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .value_byte (value_byte),
        .full       (full),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    tfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_full    (out_full),
        .res_push    (res_push),
        .res         (res)
    );

    tfp_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res),
        .full  (out_full),
        .pop   (pop),
        .dout  (res_head),
        .empty (empty)
    );

    assign status      = res_head.status;
    assign year        = res_head.year;
    assign month       = res_head.month;
    assign day         = res_head.day;
    assign hour        = res_head.hour;
    assign minute      = res_head.minute;
    assign second      = res_head.second;
    assign millisecond = res_head.millisecond;
    assign zone_offset = res_head.zone_offset;

endmodule

/* design/tfp_fifo.sv */
// ----------------------------------------------------------------------------
// tfp_fifo: small register queue
// First-in first-out queue of DEPTH entries with full and empty flags.
// ----------------------------------------------------------------------------
module tfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* design/tfp_front.sv */
// ----------------------------------------------------------------------------
// tfp_front: byte intake and classification
// Classifies each incoming byte and holds it in a short queue for the parser.
// ----------------------------------------------------------------------------
module tfp_front
    import tfp_pkg::*;
#(
    parameter int DEPTH = IN_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] value_byte,
    output logic       full,
    output logic       q_valid,
    output byte_item_t q_item,
    input  logic       q_pop
);

    byte_item_t item;
    logic       q_empty;
    logic [7:0] dsub;

    assign dsub          = value_byte - CH_ZERO;
    assign item.ch       = value_byte;
    assign item.is_soh   = (value_byte == CH_SOH);
    assign item.is_digit = (value_byte >= CH_ZERO) && (value_byte <= CH_NINE);
    assign item.dval     = dsub[3:0];

    tfp_fifo #(
        .WIDTH ($bits(byte_item_t)),
        .DEPTH (DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (item),
        .full  (full),
        .pop   (q_pop),
        .dout  (q_item),
        .empty (q_empty)
    );

    assign q_valid = !q_empty;

endmodule

/* design/tfp_back.sv */
// ----------------------------------------------------------------------------
// tfp_back: positional parser
// Checks each byte against its position under the format mode, collects the
// fields and builds one result at the end-of-field byte.
// ----------------------------------------------------------------------------
module tfp_back
    import tfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       q_valid,
    input  byte_item_t q_item,
    output logic       q_pop,
    input  logic       out_full,
    output logic       res_push,
    output result_t    res
);

    localparam logic [3:0] TGT_NONE  = 4'd0;
    localparam logic [3:0] TGT_YEAR  = 4'd1;
    localparam logic [3:0] TGT_MONTH = 4'd2;
    localparam logic [3:0] TGT_DAY   = 4'd3;
    localparam logic [3:0] TGT_HOUR  = 4'd4;
    localparam logic [3:0] TGT_MIN   = 4'd5;
    localparam logic [3:0] TGT_SEC   = 4'd6;
    localparam logic [3:0] TGT_MILLI = 4'd7;
    localparam logic [3:0] TGT_OFSH  = 4'd8;

    logic [1:0]  mode_reg;
    logic [4:0]  pos_reg,   pos_next;
    logic [1:0]  err_reg,   err_next;
    logic [13:0] acc_reg,   acc_next;
    logic [13:0] year_reg,  year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg,   day_next;
    logic [4:0]  hour_reg,  hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [9:0]  milli_reg, milli_next;
    logic        neg_reg,   neg_next;
    logic [3:0]  ofsh_reg,  ofsh_next;

    logic        use_dig;
    logic        dig_first;
    logic        do_store;
    logic        do_check;
    logic [3:0]  tgt;
    logic [13:0] lo;
    logic [13:0] hi;
    logic        use_lit;
    logic [7:0]  lit;
    logic        use_sign;
    logic        bad;
    logic [4:0]  pos_v;
    logic [13:0] acc_mul;
    logic        at_end;
    logic [1:0]  st;
    logic [10:0] ofs_mag;
    logic [10:0] ofs_val;
    logic        take;
    logic        is_stamp;

    assign q_pop    = q_valid && (!q_item.is_soh || !out_full);
    assign take     = q_pop && !q_item.is_soh && (err_reg == ST_OK);
    assign res_push = q_pop && q_item.is_soh;
    assign is_stamp = (mode_reg == MODE_UTC) || (mode_reg == MODE_ZONE);

    // Position decode: what the byte at pos_reg must be.
    always_comb
    begin
        use_dig   = 1'b0;
        dig_first = 1'b0;
        do_store  = 1'b0;
        do_check  = 1'b0;
        tgt       = TGT_NONE;
        lo        = '0;
        hi        = '0;
        use_lit   = 1'b0;
        lit       = CH_DASH;
        use_sign  = 1'b0;
        bad       = 1'b0;
        if (is_stamp && pos_reg < 5'd17)
        begin
            priority if (pos_reg <= 5'd3)
            begin
                use_dig   = 1'b1;
                dig_first = (pos_reg == 5'd0);
                do_store  = (pos_reg == 5'd3);
                tgt       = TGT_YEAR;
            end
            else if (pos_reg <= 5'd5)
            begin
                use_dig   = 1'b1;
                dig_first = (pos_reg == 5'd4);
                do_store  = (pos_reg == 5'd5);
                do_check  = 1'b1;
                tgt       = TGT_MONTH;
                lo        = 14'd1;
                hi        = 14'(MAX_MONTH);
            end
            else if (pos_reg <= 5'd7)
            begin
                use_dig   = 1'b1;
                dig_first = (pos_reg == 5'd6);
                do_store  = (pos_reg == 5'd7);
                do_check  = 1'b1;
                tgt       = TGT_DAY;
                lo        = 14'd1;
                hi        = 14'(MAX_DAY);
            end
            else if (pos_reg == 5'd8)
            begin
                use_lit = 1'b1;
                lit     = CH_DASH;
            end
            else if (pos_reg <= 5'd10)
            begin
                use_dig   = 1'b1;
                dig_first = (pos_reg == 5'd9);
                do_store  = (pos_reg == 5'd10);
                do_check  = 1'b1;
                tgt       = TGT_HOUR;
                hi        = 14'(MAX_HOUR);
            end
            else if (pos_reg == 5'd11 || pos_reg == 5'd14)
            begin
                use_lit = 1'b1;
                lit     = CH_COLON;
            end
            else if (pos_reg <= 5'd13)
            begin
                use_dig   = 1'b1;
                dig_first = (pos_reg == 5'd12);
                do_store  = (pos_reg == 5'd13);
                do_check  = 1'b1;
                tgt       = TGT_MIN;
                hi        = 14'(MAX_MINUTE);
            end
            else
            begin
                use_dig   = 1'b1;
                dig_first = (pos_reg == 5'd15);
                do_store  = (pos_reg == 5'd16);
                do_check  = 1'b1;
                tgt       = TGT_SEC;
                hi        = 14'(MAX_SECOND);
            end
        end
        else if (mode_reg == MODE_UTC)
        begin
            priority if (pos_reg == 5'd17)
            begin
                use_lit = 1'b1;
                lit     = CH_DOT;
            end
            else if (pos_reg <= 5'd20)
            begin
                use_dig   = 1'b1;
                dig_first = (pos_reg == 5'd18);
                do_store  = (pos_reg == 5'd20);
                tgt       = TGT_MILLI;
            end
            else
            begin
                bad = 1'b1;
            end
        end
        else if (mode_reg == MODE_ZONE)
        begin
            priority if (pos_reg == 5'd17)
            begin
                use_sign = 1'b1;
            end
            else if (pos_reg <= 5'd19)
            begin
                use_dig   = 1'b1;
                dig_first = (pos_reg == 5'd18);
                do_store  = (pos_reg == 5'd19);
                do_check  = 1'b1;
                tgt       = TGT_OFSH;
                lo        = 14'd1;
                hi        = 14'(MAX_OFS_HOUR);
            end
            else if (pos_reg == 5'd20)
            begin
                use_lit = 1'b1;
                lit     = CH_COLON;
            end
            else if (pos_reg <= 5'd22)
            begin
                use_dig   = 1'b1;
                dig_first = (pos_reg == 5'd21);
                do_store  = (pos_reg == 5'd22);
                do_check  = 1'b1;
                tgt       = TGT_NONE;
                hi        = 14'(MAX_MINUTE);
            end
            else
            begin
                bad = 1'b1;
            end
        end
        else if (mode_reg == MODE_DATE)
        begin
            priority if (pos_reg <= 5'd3)
            begin
                use_dig   = 1'b1;
                dig_first = (pos_reg == 5'd0);
                do_store  = (pos_reg == 5'd3);
                tgt       = TGT_YEAR;
            end
            else if (pos_reg == 5'd4 || pos_reg == 5'd7)
            begin
                use_lit = 1'b1;
                lit     = CH_DASH;
            end
            else if (pos_reg <= 5'd6)
            begin
                use_dig   = 1'b1;
                dig_first = (pos_reg == 5'd5);
                do_store  = (pos_reg == 5'd6);
                do_check  = 1'b1;
                tgt       = TGT_MONTH;
                lo        = 14'd1;
                hi        = 14'(MAX_MONTH);
            end
            else if (pos_reg <= 5'd9)
            begin
                use_dig   = 1'b1;
                dig_first = (pos_reg == 5'd8);
                do_store  = (pos_reg == 5'd9);
                do_check  = 1'b1;
                tgt       = TGT_DAY;
                lo        = 14'd1;
                hi        = 14'(MAX_DAY);
            end
            else
            begin
                bad = 1'b1;
            end
        end
        else
        begin
            bad = 1'b1;
        end
    end

    assign acc_mul = 14'({acc_reg, 3'b000}) + 14'({acc_reg, 1'b0}) + 14'(q_item.dval);

    // Byte execution.
    always_comb
    begin
        pos_v       = pos_reg;
        pos_next    = pos_reg;
        err_next    = err_reg;
        acc_next    = acc_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        milli_next  = milli_reg;
        neg_next    = neg_reg;
        ofsh_next   = ofsh_reg;
        if (take)
        begin
            if (bad)
            begin
                err_next = ST_FORMAT;
            end
            if (use_lit && q_item.ch != lit)
            begin
                err_next = ST_FORMAT;
            end
            if (use_sign)
            begin
                priority if (q_item.ch == CH_Z)
                begin
                    acc_next  = '0;
                    ofsh_next = '0;
                    pos_v     = 5'd22;
                end
                else if (q_item.ch == CH_PLUS)
                begin
                    neg_next = 1'b0;
                end
                else if (q_item.ch == CH_DASH)
                begin
                    neg_next = 1'b1;
                end
                else
                begin
                    err_next = ST_FORMAT;
                end
            end
            if (use_dig)
            begin
                if (!q_item.is_digit)
                begin
                    err_next = ST_FORMAT;
                end
                else
                begin
                    acc_next = dig_first ? 14'(q_item.dval) : acc_mul;
                    if (do_store)
                    begin
                        if (do_check && (acc_next < lo || acc_next > hi))
                        begin
                            err_next = ST_RANGE;
                        end
                        else
                        begin
                            unique case (tgt)
                                TGT_YEAR:  year_next   = acc_next;
                                TGT_MONTH: month_next  = acc_next[3:0];
                                TGT_DAY:   day_next    = acc_next[4:0];
                                TGT_HOUR:  hour_next   = acc_next[4:0];
                                TGT_MIN:   minute_next = acc_next[5:0];
                                TGT_SEC:   second_next = acc_next[5:0];
                                TGT_MILLI: milli_next  = acc_next[9:0];
                                TGT_OFSH:  ofsh_next   = acc_next[3:0];
                                default:   ;
                            endcase
                        end
                    end
                end
            end
            if (err_next == ST_OK)
            begin
                pos_next = pos_v + 5'd1;
            end
        end
        else if (res_push)
        begin
            pos_next    = '0;
            err_next    = ST_OK;
            acc_next    = '0;
            year_next   = '0;
            month_next  = '0;
            day_next    = '0;
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
            milli_next  = '0;
            neg_next    = 1'b0;
            ofsh_next   = '0;
        end
    end

    // Result assembly at the end-of-field byte.
    always_comb
    begin
        unique case (mode_reg)
            MODE_UTC:  at_end = (pos_reg == 5'd17) || (pos_reg == 5'd21);
            MODE_ZONE: at_end = (pos_reg == 5'd17) || (pos_reg == 5'd23);
            MODE_DATE: at_end = (pos_reg == 5'd10);
            default:   at_end = 1'b0;
        endcase
        st = err_reg;
        if (err_reg == ST_OK && !at_end)
        begin
            st = ST_FORMAT;
        end
        ofs_mag = 11'({ofsh_reg, 6'b000000}) - 11'({ofsh_reg, 2'b00}) + 11'(acc_reg[5:0]);
        ofs_val = '0;
        if (mode_reg == MODE_ZONE && pos_reg == 5'd23)
        begin
            ofs_val = neg_reg ? (11'd0 - ofs_mag) : ofs_mag;
        end
        res = '0;
        res.status = st;
        if (st == ST_OK)
        begin
            res.year        = year_reg;
            res.month       = month_reg;
            res.day         = day_reg;
            res.hour        = hour_reg;
            res.minute      = minute_reg;
            res.second      = second_reg;
            res.millisecond = milli_reg;
            res.zone_offset = ofs_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_UTC;
            pos_reg    <= '0;
            err_reg    <= ST_OK;
            acc_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            milli_reg  <= '0;
            neg_reg    <= 1'b0;
            ofsh_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            pos_reg    <= pos_next;
            err_reg    <= err_next;
            acc_reg    <= acc_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            milli_reg  <= milli_next;
            neg_reg    <= neg_next;
            ofsh_reg   <= ofsh_next;
        end
    end

    a_err_held: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK && !res_push) |=> (err_reg == $past(err_reg)))
        else $error("held error changed before end of field");

    a_clear_after_soh: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (pos_reg == 5'd0 && err_reg == ST_OK))
        else $error("parser state not cleared after end of field");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !out_full)
        else $error("result pushed into a full queue");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 5'd23)
        else $error("character position out of range");

    a_err_stops_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK && !res_push) |=> $stable(pos_reg))
        else $error("position advanced while an error is held");

endmodule
